// ===== rtl/core/urk_pkg.sv =====
// Shared constants, codes and types for the uptime record keeper.
`timescale 1ns / 1ps
`default_nettype none
package urk_pkg;

	localparam int REC_WORDS = 12;
	localparam int IMG_DEPTH = 2 * REC_WORDS;
	localparam int IMG_AW = $clog2(IMG_DEPTH);
	localparam int STAT_COUNT = 5;

	localparam logic [31:0] MAGIC_WORD = 32'h454E5455;
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
	localparam logic [31:0] HALF_RANGE = 32'h80000000;
	localparam logic [15:0] VERSION_NUM = 16'h0001;
	localparam logic [15:0] DIRTY_MASK = 16'h0001;
	localparam logic [15:0] FLAG_HB = 16'h0002;

	localparam logic [3:0] CMD_LOAD = 4'd0;
	localparam logic [3:0] CMD_INIT = 4'd1;
	localparam logic [3:0] CMD_ACCUM = 4'd2;
	localparam logic [3:0] CMD_TICK = 4'd3;
	localparam logic [3:0] CMD_SYNC = 4'd4;
	localparam logic [3:0] CMD_MARK_CLEAN = 4'd5;
	localparam logic [3:0] CMD_FLUSH = 4'd6;
	localparam logic [3:0] CMD_GET = 4'd7;
	localparam logic [3:0] CMD_ERASE = 4'd8;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_INIT = 2'd1;
	localparam logic [1:0] ST_NO_CLOCK = 2'd2;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_RECORD = 2'd1;
	localparam logic [1:0] KIND_STAT = 2'd2;

	localparam logic REG_TICK_FREQ = 1'b0;
	localparam logic REG_PERSIST = 1'b1;

	typedef struct packed {
		logic clear;
		logic start;
	} crc_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/uptime_record_keeper.sv =====
// Top level: boot and uptime record keeper with its command sequencer.
// The input channel (in_valid/in_stall) takes one command beat with its load,
// tick and epoch fields. The output channel (out_valid/out_stall) gives the
// result beats of that command, the final one marked by last. Registers are to be
// written through cfg_we/cfg_index/cfg_data only while the block is idle; the
// block itself does not enforce this. A load beat writes the slot image memory
// in the cycle it is accepted and gives no result, nor does an unknown command
// code. Other commands run one at a time; in_stall stays high until the last
// result beat has been loaded into the output register and S_POST has run.
// CRC words are computed in the bit-serial CRC unit and the tick-to-seconds
// fold in the divider. With a nonzero tick_freq, init runs 20 image words and
// 10 record words through the CRC unit plus a re-read of the chosen slot, if
// one is valid, and gives 12 result beats; a store gives 12 beats; get, status
// and erase give one result beat per cycle while the receiver does not stall,
// once any fold is done. When the receiver stalls, the output register holds
// its beat and the sequencer waits. Reset empties the slot images, clears the
// record and puts tick_freq at 32768 and persist_interval at 3600.
`timescale 1ns / 1ps
`default_nettype none
module uptime_record_keeper (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [3:0]  cmd,
	input  wire logic        load_slot,
	input  wire logic [3:0]  load_index,
	input  wire logic [31:0] load_data,
	input  wire logic [31:0] now_ticks,
	input  wire logic [31:0] now_epoch,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [1:0]       kind,
	output logic             target_slot,
	output logic [3:0]       word_index,
	output logic [31:0]      word_data,
	output logic             clock_synced,
	output logic             prior_clean,
	output logic             last
);
	import urk_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_VRD, S_VWAIT, S_VCRC, S_PICK, S_TRD, S_TWAIT, S_FIN1, S_FIN2,
		S_FOLD1, S_FOLD2, S_DIVW, S_FOLD3, S_FOLD4, S_DISP, S_TICK1, S_TICK2,
		S_SYNC1, S_SYNC2, S_PREP, S_SEQ, S_SCRC, S_SCRCW, S_EMIT, S_POST
	} state_t;

	typedef enum logic [1:0] {EM_STATUS, EM_STORE, EM_ERASE, EM_STATS} emit_mode_t;

	state_t      state_q;
	emit_mode_t  mode_q;
	logic [1:0]  stat_q;
	logic [4:0]  cnt_q;
	logic [3:0]  cmd_q;
	logic [31:0] ne_q;
	logic [31:0] nt_q;

	logic [31:0] freq_q;
	logic [16:0] interval_q;

	logic [31:0] seq_q, boot_q, unclean_q, session_q, cum_q;
	logic [31:0] boot_epoch_q, hb_q, down_q;
	logic [15:0] flags_q;
	logic        src_q, init_q, prevclean_q, synced_q;
	logic [31:0] last_tick_q, rem_q, persisted_q;

	logic        vslot_q, magok_q, aok_q, bok_q, cond_q;
	logic [3:0]  vidx_q, tidx_q, sidx_q;
	logic [31:0] seqa_q, seqb_q, delta_q;

	logic [IMG_DEPTH-1:0] entry_valid_q;
	logic                 rd_ok_q;
	logic [IMG_AW-1:0]    rd_addr, wr_addr;
	logic                 wr_en;
	logic [31:0]          rd_data, img_word;

	crc_cmd_t    crc_cmd;
	logic [31:0] crc_data, crc_out;
	logic        crc_busy;
	logic        div_start, div_busy;
	logic [31:0] div_q, div_r;

	logic [3:0]  word_sel;
	logic [31:0] word_out;
	logic [31:0] seq_diff;

	logic        in_acc, out_free;
	logic [1:0]  r_status, r_kind;
	logic        r_slot, r_tv, r_pc, r_last;
	logic [3:0]  r_idx;
	logic [31:0] r_data;

	logic        out_valid_q;
	logic [1:0]  status_q, kind_q;
	logic        slot_q, tv_q, pc_q, last_q;
	logic [3:0]  idx_q;
	logic [31:0] data_q;

	function automatic logic [IMG_AW-1:0] slot_addr(input logic slot, input logic [3:0] idx);
		slot_addr = slot ? IMG_AW'(idx) + IMG_AW'(REC_WORDS) : IMG_AW'(idx);
	endfunction

	assign in_stall = (state_q != S_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign wr_en = in_acc && (cmd == CMD_LOAD) && (load_index < 4'(REC_WORDS));
	assign wr_addr = slot_addr(load_slot, load_index);
	assign rd_addr = (state_q == S_TRD) ? slot_addr(src_q, tidx_q) : slot_addr(vslot_q, vidx_q);
	assign img_word = rd_ok_q ? rd_data : 32'd0;

	urk_ram #(.WIDTH(32), .DEPTH(IMG_DEPTH)) u_img (
		.clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(load_data),
		.raddr(rd_addr), .rdata(rd_data)
	);

	assign crc_cmd.clear = ((state_q == S_VRD) && (vidx_q == 4'd0)) || (state_q == S_SEQ);
	assign crc_cmd.start = ((state_q == S_VWAIT) && (vidx_q != 4'd10)) || (state_q == S_SCRC);
	assign crc_data = (state_q == S_SCRC) ? word_out : img_word;

	urk_crc u_crc (
		.clk(clk), .arst_n(arst_n), .cmd(crc_cmd), .data(crc_data),
		.busy(crc_busy), .crc(crc_out)
	);

	assign div_start = (state_q == S_FOLD2);

	urk_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(delta_q + rem_q),
		.divisor(freq_q), .busy(div_busy), .quotient(div_q), .remainder(div_r)
	);

	assign seq_diff = seqa_q - seqb_q;
	assign word_sel = (state_q == S_EMIT) ? cnt_q[3:0] : sidx_q;

	always_comb begin
		case (word_sel)
			4'd0:    word_out = MAGIC_WORD;
			4'd1:    word_out = {flags_q, VERSION_NUM};
			4'd2:    word_out = seq_q;
			4'd3:    word_out = boot_q;
			4'd4:    word_out = unclean_q;
			4'd5:    word_out = session_q;
			4'd6:    word_out = cum_q;
			4'd7:    word_out = boot_epoch_q;
			4'd8:    word_out = hb_q;
			4'd9:    word_out = down_q;
			4'd10:   word_out = crc_out;
			default: word_out = 32'd0;
		endcase
	end

	always_comb begin
		r_status = ST_OK;
		r_kind = KIND_STATUS;
		r_slot = 1'b0;
		r_idx = 4'd0;
		r_data = 32'd0;
		r_tv = 1'b0;
		r_pc = 1'b0;
		r_last = 1'b0;
		unique case (mode_q)
			EM_STATUS: begin
				r_status = stat_q;
				r_last = 1'b1;
			end
			EM_STORE: begin
				r_kind = KIND_RECORD;
				r_slot = ~src_q;
				r_idx = cnt_q[3:0];
				r_data = word_out;
				r_last = (cnt_q == 5'(REC_WORDS - 1));
			end
			EM_ERASE: begin
				r_kind = KIND_RECORD;
				r_slot = (cnt_q >= 5'(REC_WORDS));
				r_idx = r_slot ? 4'(cnt_q - 5'(REC_WORDS)) : cnt_q[3:0];
				r_last = (cnt_q == 5'(IMG_DEPTH - 1));
			end
			EM_STATS: begin
				r_kind = KIND_STAT;
				r_idx = cnt_q[3:0];
				r_tv = synced_q;
				r_pc = prevclean_q;
				r_last = (cnt_q == 5'(STAT_COUNT - 1));
				case (cnt_q[2:0])
					3'd0:    r_data = boot_q;
					3'd1:    r_data = unclean_q;
					3'd2:    r_data = session_q;
					3'd3:    r_data = cum_q;
					default: r_data = down_q;
				endcase
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			status_q <= r_status;
			kind_q <= r_kind;
			slot_q <= r_slot;
			idx_q <= r_idx;
			data_q <= r_data;
			tv_q <= r_tv;
			pc_q <= r_pc;
			last_q <= r_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (wr_en) begin
				entry_valid_q[wr_addr] <= 1'b1;
			end
			rd_ok_q <= entry_valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= 32'd32768;
			interval_q <= 17'd3600;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TICK_FREQ: freq_q <= cfg_data;
				REG_PERSIST:   interval_q <= cfg_data[16:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= EM_STATUS;
			stat_q <= ST_OK;
			cnt_q <= '0;
			cmd_q <= CMD_LOAD;
			ne_q <= '0;
			nt_q <= '0;
			seq_q <= '0;
			boot_q <= '0;
			unclean_q <= '0;
			session_q <= '0;
			cum_q <= '0;
			boot_epoch_q <= '0;
			hb_q <= '0;
			down_q <= '0;
			flags_q <= '0;
			src_q <= 1'b1;
			init_q <= 1'b0;
			prevclean_q <= 1'b0;
			synced_q <= 1'b0;
			last_tick_q <= '0;
			rem_q <= '0;
			persisted_q <= '0;
			vslot_q <= 1'b0;
			vidx_q <= '0;
			tidx_q <= '0;
			sidx_q <= '0;
			magok_q <= 1'b0;
			aok_q <= 1'b0;
			bok_q <= 1'b0;
			cond_q <= 1'b0;
			seqa_q <= '0;
			seqb_q <= '0;
			delta_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cmd_q <= cmd;
						nt_q <= now_ticks;
						ne_q <= now_epoch;
						cnt_q <= '0;
						case (cmd) inside
							CMD_INIT: begin
								seq_q <= '0;
								boot_q <= '0;
								unclean_q <= '0;
								session_q <= '0;
								cum_q <= '0;
								boot_epoch_q <= '0;
								hb_q <= '0;
								down_q <= '0;
								flags_q <= '0;
								src_q <= 1'b1;
								rem_q <= '0;
								persisted_q <= '0;
								prevclean_q <= 1'b0;
								synced_q <= 1'b0;
								if (freq_q == 32'd0) begin
									mode_q <= EM_STATUS;
									stat_q <= ST_NO_CLOCK;
									state_q <= S_EMIT;
								end else begin
									last_tick_q <= now_ticks;
									vslot_q <= 1'b0;
									vidx_q <= '0;
									aok_q <= 1'b0;
									bok_q <= 1'b0;
									state_q <= S_VRD;
								end
							end
							[CMD_ACCUM:CMD_GET]: begin
								if (!init_q) begin
									mode_q <= EM_STATUS;
									stat_q <= ST_NOT_INIT;
									state_q <= S_EMIT;
								end else if (freq_q == 32'd0) begin
									state_q <= S_DISP;
								end else begin
									state_q <= S_FOLD1;
								end
							end
							CMD_ERASE: begin
								mode_q <= EM_ERASE;
								state_q <= S_EMIT;
							end
							default: begin
							end
						endcase
					end
				end
				S_VRD: state_q <= S_VWAIT;
				S_VWAIT: begin
					if (vidx_q == 4'd0) begin
						magok_q <= (img_word == MAGIC_WORD);
					end
					if (vidx_q == 4'd2) begin
						if (vslot_q) begin
							seqb_q <= img_word;
						end else begin
							seqa_q <= img_word;
						end
					end
					if (vidx_q == 4'd10) begin
						if (vslot_q) begin
							bok_q <= magok_q && (img_word == crc_out);
							state_q <= S_PICK;
						end else begin
							aok_q <= magok_q && (img_word == crc_out);
							vslot_q <= 1'b1;
							vidx_q <= '0;
							state_q <= S_VRD;
						end
					end else begin
						state_q <= S_VCRC;
					end
				end
				S_VCRC: begin
					if (!crc_busy) begin
						vidx_q <= vidx_q + 4'd1;
						state_q <= S_VRD;
					end
				end
				S_PICK: begin
					tidx_q <= 4'd1;
					if (aok_q && bok_q) begin
						src_q <= (seq_diff >= HALF_RANGE);
						state_q <= S_TRD;
					end else if (aok_q || bok_q) begin
						src_q <= bok_q;
						state_q <= S_TRD;
					end else begin
						state_q <= S_FIN2;
					end
				end
				S_TRD: state_q <= S_TWAIT;
				S_TWAIT: begin
					case (tidx_q)
						4'd1:    flags_q <= img_word[31:16];
						4'd2:    seq_q <= img_word;
						4'd3:    boot_q <= img_word;
						4'd4:    unclean_q <= img_word;
						4'd5:    session_q <= img_word;
						4'd6:    cum_q <= img_word;
						4'd7:    boot_epoch_q <= img_word;
						4'd8:    hb_q <= img_word;
						default: down_q <= img_word;
					endcase
					if (tidx_q == 4'd9) begin
						state_q <= S_FIN1;
					end else begin
						tidx_q <= tidx_q + 4'd1;
						state_q <= S_TRD;
					end
				end
				S_FIN1: begin
					prevclean_q <= ((flags_q & DIRTY_MASK) == 16'd0);
					if ((flags_q & DIRTY_MASK) != 16'd0) begin
						unclean_q <= unclean_q + 32'd1;
					end
					state_q <= S_FIN2;
				end
				S_FIN2: begin
					boot_q <= boot_q + 32'd1;
					session_q <= '0;
					boot_epoch_q <= '0;
					flags_q <= flags_q | DIRTY_MASK;
					init_q <= 1'b1;
					state_q <= S_SEQ;
				end
				S_FOLD1: begin
					delta_q <= nt_q - last_tick_q;
					last_tick_q <= nt_q;
					state_q <= S_FOLD2;
				end
				S_FOLD2: state_q <= S_DIVW;
				S_DIVW: begin
					if (!div_busy) begin
						state_q <= S_FOLD3;
					end
				end
				S_FOLD3: begin
					session_q <= session_q + div_q;
					state_q <= S_FOLD4;
				end
				S_FOLD4: begin
					cum_q <= cum_q + div_q;
					rem_q <= div_r;
					state_q <= S_DISP;
				end
				S_DISP: begin
					case (cmd_q) inside
						CMD_TICK: state_q <= S_TICK1;
						CMD_SYNC: state_q <= S_SYNC1;
						CMD_MARK_CLEAN, CMD_FLUSH: state_q <= S_PREP;
						CMD_GET: begin
							mode_q <= EM_STATS;
							state_q <= S_EMIT;
						end
						default: begin
							mode_q <= EM_STATUS;
							stat_q <= ST_OK;
							state_q <= S_EMIT;
						end
					endcase
				end
				S_TICK1: begin
					delta_q <= session_q - persisted_q;
					state_q <= S_TICK2;
				end
				S_TICK2: begin
					if (delta_q >= {15'd0, interval_q}) begin
						if (synced_q) begin
							hb_q <= ne_q;
						end
						state_q <= S_SEQ;
					end else begin
						mode_q <= EM_STATUS;
						stat_q <= ST_OK;
						state_q <= S_EMIT;
					end
				end
				S_SYNC1: begin
					delta_q <= ne_q - hb_q;
					cond_q <= ((flags_q & FLAG_HB) != 16'd0) && (hb_q != 32'd0) && (ne_q >= hb_q);
					state_q <= S_SYNC2;
				end
				S_SYNC2: begin
					if (cond_q) begin
						down_q <= down_q + delta_q;
					end
					synced_q <= 1'b1;
					flags_q <= flags_q | FLAG_HB;
					boot_epoch_q <= ne_q;
					hb_q <= ne_q;
					state_q <= S_SEQ;
				end
				S_PREP: begin
					if (synced_q) begin
						hb_q <= ne_q;
					end
					if (cmd_q == CMD_MARK_CLEAN) begin
						flags_q <= flags_q & ~DIRTY_MASK;
					end
					state_q <= S_SEQ;
				end
				S_SEQ: begin
					seq_q <= seq_q + 32'd1;
					sidx_q <= '0;
					state_q <= S_SCRC;
				end
				S_SCRC: state_q <= S_SCRCW;
				S_SCRCW: begin
					if (!crc_busy) begin
						if (sidx_q == 4'd9) begin
							mode_q <= EM_STORE;
							cnt_q <= '0;
							state_q <= S_EMIT;
						end else begin
							sidx_q <= sidx_q + 4'd1;
							state_q <= S_SCRC;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						cnt_q <= cnt_q + 5'd1;
						if (r_last) begin
							state_q <= S_POST;
						end
					end
				end
				S_POST: begin
					if (mode_q == EM_STORE) begin
						src_q <= ~src_q;
						persisted_q <= session_q;
					end else if (mode_q == EM_ERASE) begin
						seq_q <= '0;
						boot_q <= '0;
						unclean_q <= '0;
						session_q <= '0;
						cum_q <= '0;
						boot_epoch_q <= '0;
						hb_q <= '0;
						down_q <= '0;
						flags_q <= '0;
						init_q <= 1'b0;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign kind = kind_q;
	assign target_slot = slot_q;
	assign word_index = idx_q;
	assign word_data = data_q;
	assign clock_synced = tv_q;
	assign prior_clean = pc_q;
	assign last = last_q;
endmodule
`default_nettype wire

// ===== rtl/core/urk_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module urk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 24
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/urk_crc.sv =====
// Bit-serial reflected CRC32 unit, one data bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module urk_crc (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire urk_pkg::crc_cmd_t cmd,
	input  wire logic [31:0]       data,
	output logic                   busy,
	output logic [31:0]            crc
);
	import urk_pkg::*;

	logic [31:0] c_q;
	logic [31:0] dat_q;
	logic [4:0]  bit_q;
	logic        busy_q;
	logic        fb;

	assign fb = c_q[0] ^ dat_q[0];
	assign busy = busy_q;
	assign crc = ~c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= CRC_INIT;
			dat_q <= '0;
			bit_q <= '0;
			busy_q <= 1'b0;
		end else if (cmd.clear) begin
			c_q <= CRC_INIT;
			busy_q <= 1'b0;
		end else if (cmd.start) begin
			dat_q <= data;
			bit_q <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			c_q <= (c_q >> 1) ^ (fb ? CRC_POLY : 32'd0);
			dat_q <= dat_q >> 1;
			bit_q <= bit_q + 5'd1;
			if (bit_q == 5'd31) begin
				busy_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/urk_div.sv =====
// Restoring 32-bit divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module urk_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             busy,
	output logic [31:0]      quotient,
	output logic [31:0]      remainder
);
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [4:0]  step_q;
	logic        busy_q;
	logic [32:0] shifted;
	logic [32:0] diff;
	logic        ge;

	assign shifted = {rem_q, quo_q[31]};
	assign ge = shifted >= {1'b0, dvs_q};
	assign diff = shifted - {1'b0, dvs_q};
	assign busy = busy_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			quo_q <= '0;
			dvs_q <= '0;
			step_q <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
			step_q <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : shifted[31:0];
			quo_q <= {quo_q[30:0], ge};
			step_q <= step_q + 5'd1;
			if (step_q == 5'd31) begin
				busy_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== tb/uptime_record_keeper_test.sv =====
// Self-checking testbench for the uptime record keeper: random and directed command beats.
`timescale 1ns / 1ps
`default_nettype none
module uptime_record_keeper_test;
	import urk_pkg::*;

	typedef struct {
		logic [3:0]  cmd;
		logic        slot;
		logic [3:0]  idx;
		logic [31:0] data;
		logic [31:0] ticks;
		logic [31:0] epoch;
	} command_t;

	typedef struct {
		logic [1:0]  status;
		logic [1:0]  kind;
		logic        slot;
		logic [3:0]  idx;
		logic [31:0] data;
		logic        tv;
		logic        pc;
		logic        lst;
	} beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [3:0]  cmd = '0;
	logic        load_slot = 1'b0;
	logic [3:0]  load_index = '0;
	logic [31:0] load_data = '0;
	logic [31:0] now_ticks = '0;
	logic [31:0] now_epoch = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [1:0]  kind;
	logic        target_slot;
	logic [3:0]  word_index;
	logic [31:0] word_data;
	logic        clock_synced;
	logic        prior_clean;
	logic        last;

	uptime_record_keeper dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	command_t pending_cmds[$];
	command_t driven_cmd;
	beat_t    expected_beats[$];
	int       errors = 0;
	logic     calm = 1'b0;
	logic     hold_go = 1'b0;
	int       hold_left = 0;
	int       cycles = 0;
	logic [31:0] tick_now = '0;
	logic [31:0] epoch_now = 32'd1000;

	// Shadow of the block's state.
	logic [31:0] freq_reg = 32'd32768;
	logic [16:0] persist_reg = 17'd3600;
	logic [31:0] seq_c, boots_c, unclean_c, session_c, cumul_c, boot_ep, hb_ep, down_c;
	logic [15:0] flags_c;
	logic        src_slot, inited, prev_clean, synced;
	logic [31:0] last_ticks, tick_rem, persisted;
	logic [1:0][11:0][31:0] images;

	function automatic logic [31:0] image_crc(input logic [11:0][31:0] w);
		logic [31:0] c;
		c = CRC_INIT;
		for (int i = 0; i < 10; i++)
			for (int k = 0; k < 4; k++) begin
				c ^= {24'b0, w[i][8*k +: 8]};
				for (int b = 0; b < 8; b++)
					c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
			end
		return ~c;
	endfunction

	function automatic logic image_valid(input logic [11:0][31:0] w);
		return w[0] == MAGIC_WORD && w[10] == image_crc(w);
	endfunction

	task automatic clear_record();
		{seq_c, boots_c, unclean_c, session_c, cumul_c, boot_ep, hb_ep, down_c} = '0;
		flags_c = '0;
	endtask

	task automatic take_image(input logic s);
		flags_c = images[s][1][31:16];
		seq_c = images[s][2];
		boots_c = images[s][3];
		unclean_c = images[s][4];
		session_c = images[s][5];
		cumul_c = images[s][6];
		boot_ep = images[s][7];
		hb_ep = images[s][8];
		down_c = images[s][9];
		src_slot = s;
	endtask

	task automatic push_beat(input logic [1:0] st, input logic [1:0] kd, input logic sl,
			input logic [3:0] ix, input logic [31:0] dt, input logic tv, input logic pc);
		beat_t b;
		b = '{st, kd, sl, ix, dt, tv, pc, 1'b0};
		expected_beats.push_back(b);
	endtask

	task automatic store_record();
		logic [11:0][31:0] w;
		logic tgt;
		tgt = ~src_slot;
		seq_c += 1;
		w = '0;
		w[0] = MAGIC_WORD;
		w[1] = {flags_c, VERSION_NUM};
		w[2] = seq_c;
		w[3] = boots_c;
		w[4] = unclean_c;
		w[5] = session_c;
		w[6] = cumul_c;
		w[7] = boot_ep;
		w[8] = hb_ep;
		w[9] = down_c;
		w[10] = image_crc(w);
		for (int i = 0; i < REC_WORDS; i++)
			push_beat(ST_OK, KIND_RECORD, tgt, i[3:0], w[i], 1'b0, 1'b0);
		src_slot = tgt;
		persisted = session_c;
	endtask

	task automatic fold_elapsed(input logic [31:0] nowt);
		logic [31:0] total, secs;
		if (freq_reg != 0) begin
			total = (nowt - last_ticks) + tick_rem;
			last_ticks = nowt;
			secs = total / freq_reg;
			tick_rem = total % freq_reg;
			session_c += secs;
			cumul_c += secs;
		end
	endtask

	task automatic track_command(input command_t c);
		logic a_ok, b_ok;
		logic [31:0] d;
		int prior_count;
		prior_count = expected_beats.size();
		if (c.cmd == CMD_LOAD) begin
			if (c.idx < REC_WORDS)
				images[c.slot][c.idx] = c.data;
		end else if (c.cmd == CMD_INIT) begin
			clear_record();
			src_slot = 1'b1;
			tick_rem = '0;
			persisted = '0;
			prev_clean = 1'b0;
			synced = 1'b0;
			if (freq_reg == 0) begin
				push_beat(ST_NO_CLOCK, KIND_STATUS, 1'b0, '0, '0, 1'b0, 1'b0);
			end else begin
				last_ticks = c.ticks;
				a_ok = image_valid(images[0]);
				b_ok = image_valid(images[1]);
				d = images[0][2] - images[1][2];
				if (a_ok && b_ok)
					take_image(d < HALF_RANGE ? 1'b0 : 1'b1);
				else if (a_ok)
					take_image(1'b0);
				else if (b_ok)
					take_image(1'b1);
				if (a_ok || b_ok) begin
					prev_clean = (flags_c & DIRTY_MASK) == 0;
					if (!prev_clean)
						unclean_c += 1;
				end
				boots_c += 1;
				session_c = '0;
				boot_ep = '0;
				flags_c |= DIRTY_MASK;
				inited = 1'b1;
				store_record();
			end
		end else if (c.cmd >= CMD_ACCUM && c.cmd <= CMD_GET) begin
			if (!inited) begin
				push_beat(ST_NOT_INIT, KIND_STATUS, 1'b0, '0, '0, 1'b0, 1'b0);
			end else begin
				fold_elapsed(c.ticks);
				case (c.cmd)
					CMD_ACCUM: push_beat(ST_OK, KIND_STATUS, 1'b0, '0, '0, 1'b0, 1'b0);
					CMD_TICK: begin
						if (session_c - persisted >= {15'b0, persist_reg}) begin
							if (synced)
								hb_ep = c.epoch;
							store_record();
						end else begin
							push_beat(ST_OK, KIND_STATUS, 1'b0, '0, '0, 1'b0, 1'b0);
						end
					end
					CMD_SYNC: begin
						if ((flags_c & FLAG_HB) != 0 && hb_ep != 0 && c.epoch >= hb_ep)
							down_c += c.epoch - hb_ep;
						synced = 1'b1;
						flags_c |= FLAG_HB;
						boot_ep = c.epoch;
						hb_ep = c.epoch;
						store_record();
					end
					CMD_MARK_CLEAN, CMD_FLUSH: begin
						if (synced)
							hb_ep = c.epoch;
						if (c.cmd == CMD_MARK_CLEAN)
							flags_c &= ~DIRTY_MASK;
						store_record();
					end
					default: begin
						push_beat(ST_OK, KIND_STAT, 1'b0, 4'd0, boots_c, synced, prev_clean);
						push_beat(ST_OK, KIND_STAT, 1'b0, 4'd1, unclean_c, synced, prev_clean);
						push_beat(ST_OK, KIND_STAT, 1'b0, 4'd2, session_c, synced, prev_clean);
						push_beat(ST_OK, KIND_STAT, 1'b0, 4'd3, cumul_c, synced, prev_clean);
						push_beat(ST_OK, KIND_STAT, 1'b0, 4'd4, down_c, synced, prev_clean);
					end
				endcase
			end
		end else if (c.cmd == CMD_ERASE) begin
			for (int i = 0; i < 2 * REC_WORDS; i++)
				push_beat(ST_OK, KIND_RECORD, 1'(i / REC_WORDS), 4'(i % REC_WORDS), '0,
					1'b0, 1'b0);
			clear_record();
			inited = 1'b0;
		end
		if (expected_beats.size() > prior_count)
			expected_beats[expected_beats.size() - 1].lst = 1'b1;
	endtask

	// Sender.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				track_command(driven_cmd);
			if (!in_valid || !in_stall) begin
				if (pending_cmds.size() != 0 && (calm || $urandom_range(0, 99) >= 27)) begin
					driven_cmd = pending_cmds.pop_front();
					in_valid <= 1'b1;
					cmd <= driven_cmd.cmd;
					load_slot <= driven_cmd.slot;
					load_index <= driven_cmd.idx;
					load_data <= driven_cmd.data;
					now_ticks <= driven_cmd.ticks;
					now_epoch <= driven_cmd.epoch;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver, with an occasional long hold-off.
	always @(posedge clk) begin
		if (hold_go)
			hold_left <= 3000;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
		out_stall <= (hold_go || hold_left > 1) ? 1'b1 : (!calm && $urandom_range(0, 99) < 27);
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		beat_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_beats.size() == 0) begin
				report_mismatch("unexpected beat, word_data", word_data, '0);
			end else begin
				e = expected_beats.pop_front();
				if (status !== e.status) report_mismatch("status", status, e.status);
				if (kind !== e.kind) report_mismatch("kind", kind, e.kind);
				if (target_slot !== e.slot) report_mismatch("target_slot", target_slot, e.slot);
				if (word_index !== e.idx) report_mismatch("word_index", word_index, e.idx);
				if (word_data !== e.data) report_mismatch("word_data", word_data, e.data);
				if (clock_synced !== e.tv) report_mismatch("clock_synced", clock_synced, e.tv);
				if (prior_clean !== e.pc)
					report_mismatch("prior_clean", prior_clean, e.pc);
				if (last !== e.lst) report_mismatch("last", last, e.lst);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == 3000000) begin
			$display("uptime_record_keeper test failed");
			$finish;
		end
	end

	task automatic add(input logic [3:0] c, input logic [31:0] s, input logic [31:0] ix,
			input logic [31:0] dt, input logic [31:0] tk, input logic [31:0] ep);
		command_t item;
		item = '{c, s[0], ix[3:0], dt, tk, ep};
		pending_cmds.push_back(item);
	endtask

	task automatic wait_idle();
		while (pending_cmds.size() != 0 || in_valid || expected_beats.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_regs(input logic [31:0] f, input logic [16:0] p);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_TICK_FREQ;
		cfg_data <= f;
		freq_reg = f;
		@(posedge clk);
		cfg_index <= REG_PERSIST;
		cfg_data <= {15'b0, p};
		persist_reg = p;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_images();
		logic [1:0][11:0][31:0] w;
		logic [31:0] seq_a;
		int pick;
		seq_a = $urandom;
		pick = $urandom_range(0, 3);
		for (int s = 0; s < 2; s++) begin
			for (int i = 0; i < REC_WORDS; i++)
				w[s][i] = $urandom;
			w[s][0] = MAGIC_WORD;
			w[s][1][15:0] = VERSION_NUM;
			w[s][2] = s == 0 ? seq_a : (pick == 0 ? seq_a + 1 : pick == 1 ? seq_a - 1 :
				pick == 2 ? seq_a + HALF_RANGE : $urandom);
			w[s][10] = image_crc(w[s]);
			if ($urandom_range(0, 3) == 0)
				w[s][$urandom_range(0, 10)] ^= 32'h1 << $urandom_range(0, 31);
			for (int i = 0; i < REC_WORDS; i++)
				add(CMD_LOAD, s, i, w[s][i], $urandom, $urandom);
		end
	endtask

	task automatic add_random_command();
		int r;
		r = $urandom_range(0, 99);
		tick_now += ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 150000);
		epoch_now += ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 5000);
		if (r < 20) add(CMD_TICK, $urandom, $urandom, $urandom, tick_now, epoch_now);
		else if (r < 32) add(CMD_ACCUM, $urandom, $urandom, $urandom, tick_now, epoch_now);
		else if (r < 46) add(CMD_SYNC, $urandom, $urandom, $urandom, tick_now, epoch_now);
		else if (r < 56) add(CMD_MARK_CLEAN, $urandom, $urandom, $urandom, tick_now, epoch_now);
		else if (r < 66) add(CMD_FLUSH, $urandom, $urandom, $urandom, tick_now, epoch_now);
		else if (r < 80) add(CMD_GET, $urandom, $urandom, $urandom, tick_now, epoch_now);
		else if (r < 85) add(CMD_ERASE, $urandom, $urandom, $urandom, tick_now, epoch_now);
		else if (r < 90) add(CMD_INIT, $urandom, $urandom, $urandom, tick_now, epoch_now);
		else if (r < 95)
			add(4'($urandom_range(9, 15)), $urandom, $urandom, $urandom, $urandom, $urandom);
		else add(CMD_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic run_session(input logic [31:0] f, input logic [16:0] p, input int n,
			input logic quiet, input logic squeeze, input logic fill);
		wait_idle();
		write_regs(f, p);
		calm <= quiet;
		if (fill)
			load_images();
		add(CMD_INIT, 0, 0, 0, tick_now, epoch_now);
		repeat (n) add_random_command();
		if (squeeze) begin
			repeat (40) @(posedge clk);
			hold_go <= 1'b1;
			@(posedge clk);
			hold_go <= 1'b0;
		end
	endtask

	initial begin
		src_slot = 1'b1;
		inited = 1'b0;
		prev_clean = 1'b0;
		synced = 1'b0;
		last_ticks = '0;
		tick_rem = '0;
		persisted = '0;
		images = '0;
		clear_record();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Commands before init, an ignored load, a load of the unused word 11 and an unknown code.
		add(CMD_ACCUM, 0, 0, 0, 0, 0);
		add(CMD_TICK, 0, 0, 0, 0, 0);
		add(CMD_SYNC, 0, 0, 0, 0, 32'hFFFFFFFF);
		add(CMD_MARK_CLEAN, 0, 0, 0, 0, 0);
		add(CMD_FLUSH, 0, 0, 0, 0, 0);
		add(CMD_GET, 0, 0, 0, 0, 0);
		add(4'hF, 1, 15, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		add(CMD_LOAD, 1, 15, 32'hFFFFFFFF, 0, 0);
		add(CMD_LOAD, 0, 11, 32'hFFFFFFFF, 0, 0);
		// Empty images give a fresh record.
		add(CMD_INIT, 0, 0, 0, 32'h10, 0);
		add(CMD_TICK, 0, 0, 0, 32'hFFFFFFFF, 0);
		add(CMD_SYNC, 0, 0, 0, 32'hFFFFFFFF, 32'd1000);
		add(CMD_SYNC, 0, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF);
		add(CMD_SYNC, 0, 0, 0, 32'h0, 32'd5);
		add(CMD_MARK_CLEAN, 0, 0, 0, 32'h0, 32'd9);
		add(CMD_FLUSH, 0, 0, 0, 32'h7FFFFFFF, 32'd20);
		add(CMD_GET, 0, 0, 0, 32'h80000000, 32'd30);
		add(CMD_ERASE, 0, 0, 0, 0, 0);
		add(CMD_ACCUM, 0, 0, 0, 0, 0);
		wait_idle();
		// No clock: init reports it, later commands stay uninitialized.
		write_regs(32'd0, 17'd1);
		add(CMD_INIT, 0, 0, 0, 32'h55, 0);
		add(CMD_GET, 0, 0, 0, 0, 0);

		run_session(32'd32768, 17'd3600, 5, 1'b0, 1'b1, 1'b1);
		run_session(32'd1, 17'd1, 4, 1'b1, 1'b0, 1'b0);
		run_session(32'hFFFFFFFF, 17'd86400, 3, 1'b0, 1'b0, 1'b0);
		run_session(32'd1000, 17'd0, 3, 1'b0, 1'b0, 1'b0);
		run_session(32'd0, 17'd2, 3, 1'b0, 1'b0, 1'b0);
		run_session(32'd7, 17'h1FFFF, 3, 1'b0, 1'b0, 1'b0);
		run_session(32'd50000, 17'd30, 5, 1'b0, 1'b0, 1'b1);

		wait_idle();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("uptime_record_keeper test passed");
		else
			$display("uptime_record_keeper test failed");
		$finish;
	end
endmodule
`default_nettype wire
